[rtl/syn_pit_pkg.sv]
// Package for the SYN pair interval tracker.
// Holds the protocol constants, event codes and the controller/datapath interface types.
// No dependencies.
package syn_pit_pkg;

    localparam logic [15:0] ETHERTYPE_IPV4  = 16'h0800;
    localparam logic [7:0]  PROTO_TCP       = 8'd6;
    localparam logic [15:0] MIN_FRAME_BYTES = 16'd54;

    localparam logic [1:0] EV_IGNORED = 2'd0;
    localparam logic [1:0] EV_STORED  = 2'd1;
    localparam logic [1:0] EV_MATCHED = 2'd2;
    localparam logic [1:0] EV_FULL    = 2'd3;

    typedef struct packed {
        logic clear_wr;
        logic capture;
        logic mod_start;
        logic mod_step;
        logic rd_port;
        logic rd_reg;
        logic resolve;
    } t_ctl_cmd;

    typedef struct packed {
        logic clear_last;
        logic mod_last;
        logic out_busy;
    } t_ctl_status;

endpackage

[rtl/syn_pair_interval_tracker_core.sv]
// Sequence: an accepted beat is captured and its set is read from the table memory when the
// set count is a power of two; otherwise a set index unit and a separate table read come first.
// A beat is resolved and its set written back before the next beat is accepted; a stalled
// result holds off the resolve and so the next beat. The result is registered on resolve.
// Reset: synchronous, active low; a clearing pass then sweeps the valid bits, one set per
// cycle, during which no beat is accepted.
// Top level; depends on syn_pit_pkg, syn_pit_ctrl and syn_pit_dp.
module syn_pair_interval_tracker_core import syn_pit_pkg::*; #(
    parameter int TABLE_SETS = 2048,
    parameter int TABLE_WAYS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [15:0] i_frame_length,
    input  logic [15:0] i_ether_type,
    input  logic [7:0]  i_ip_protocol,
    input  logic [31:0] i_source_address,
    input  logic [31:0] i_destination_address,
    input  logic        i_syn_flag,
    input  logic        i_ack_flag,
    input  logic [63:0] i_timestamp_ns,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_event_res,
    output logic [63:0] o_elapsed_ns,
    output logic [31:0] o_flow_source,
    output logic [31:0] o_flow_destination
);

    t_ctl_cmd    cmd;
    t_ctl_status status;

    syn_pit_ctrl #(
        .TABLE_SETS (TABLE_SETS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    syn_pit_dp #(
        .TABLE_SETS (TABLE_SETS),
        .TABLE_WAYS (TABLE_WAYS)
    ) u_dp (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cmd                 (cmd),
        .o_status              (status),
        .i_frame_length        (i_frame_length),
        .i_ether_type          (i_ether_type),
        .i_ip_protocol         (i_ip_protocol),
        .i_source_address      (i_source_address),
        .i_destination_address (i_destination_address),
        .i_syn_flag            (i_syn_flag),
        .i_ack_flag            (i_ack_flag),
        .i_timestamp_ns        (i_timestamp_ns),
        .o_out_valid           (o_out_valid),
        .i_out_stall           (i_out_stall),
        .o_event_res           (o_event_res),
        .o_elapsed_ns          (o_elapsed_ns),
        .o_flow_source         (o_flow_source),
        .o_flow_destination    (o_flow_destination)
    );

endmodule

[rtl/syn_pit_ctrl.sv]
// Controller state machine for the SYN pair interval tracker.
// Sequences the table clear, set index, table read and resolve steps.
// Depends on syn_pit_pkg.
module syn_pit_ctrl import syn_pit_pkg::*; #(
    parameter int TABLE_SETS = 2048
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_ctl_status i_status,
    output t_ctl_cmd    o_cmd
);

    localparam bit SETS_POW2 = ((TABLE_SETS & (TABLE_SETS - 1)) == 0);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_MOD   = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_CHECK = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear_wr = 1'b1;
                if (i_status.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    if (SETS_POW2) begin
                        o_cmd.rd_port = 1'b1;
                        n_state       = S_CHECK;
                    end else begin
                        o_cmd.mod_start = 1'b1;
                        n_state         = S_MOD;
                    end
                end
            end
            S_MOD: begin
                o_cmd.mod_step = 1'b1;
                if (i_status.mod_last) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                o_cmd.rd_reg = 1'b1;
                n_state      = S_CHECK;
            end
            S_CHECK: begin
                if (!i_status.out_busy) begin
                    o_cmd.resolve = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

endmodule

[rtl/syn_pit_dp.sv]
// Datapath for the SYN pair interval tracker.
// Holds the captured beat, set index unit, flow table memories and the output register.
// Depends on syn_pit_pkg.
module syn_pit_dp import syn_pit_pkg::*; #(
    parameter int TABLE_SETS = 2048,
    parameter int TABLE_WAYS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_ctl_cmd    i_cmd,
    output t_ctl_status o_status,
    input  logic [15:0] i_frame_length,
    input  logic [15:0] i_ether_type,
    input  logic [7:0]  i_ip_protocol,
    input  logic [31:0] i_source_address,
    input  logic [31:0] i_destination_address,
    input  logic        i_syn_flag,
    input  logic        i_ack_flag,
    input  logic [63:0] i_timestamp_ns,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_event_res,
    output logic [63:0] o_elapsed_ns,
    output logic [31:0] o_flow_source,
    output logic [31:0] o_flow_destination
);

    localparam int SET_W = (TABLE_SETS > 1) ? $clog2(TABLE_SETS) : 1;
    localparam int WAY_W = (TABLE_WAYS > 1) ? $clog2(TABLE_WAYS) : 1;
    localparam logic [SET_W-1:0] SET_LAST  = SET_W'(TABLE_SETS - 1);
    localparam logic [31:0]      SET_MASK  = 32'(TABLE_SETS - 1);
    localparam logic [31:0]      SETS_32   = 32'(TABLE_SETS);
    localparam int               MOD_SHIFT = 32 + SET_W;
    localparam logic [63:0]      MOD_NUM   = 64'd1 << MOD_SHIFT;
    localparam logic [63:0]      MOD_DIV   = 64'(TABLE_SETS);
    localparam logic [32:0]      MOD_RECIP = 33'((MOD_NUM + MOD_DIV - 64'd1) / MOD_DIV);

    logic [TABLE_WAYS-1:0]       mem_valid [TABLE_SETS];
    logic [TABLE_WAYS-1:0][63:0] mem_pair  [TABLE_SETS];
    logic [TABLE_WAYS-1:0][63:0] mem_time  [TABLE_SETS];

    logic [31:0]      r_src;
    logic [31:0]      r_dst;
    logic [63:0]      r_time;
    logic             r_qual;
    logic [SET_W-1:0] r_clr_cnt;
    logic [SET_W-1:0] r_mod_rem;
    logic [31:0]      r_mod_x;
    logic [31:0]      r_mod_q;
    logic             r_mod_cnt;
    logic [SET_W-1:0] r_set;

    logic [TABLE_WAYS-1:0]       r_rd_valid;
    logic [TABLE_WAYS-1:0][63:0] r_rd_pair;
    logic [TABLE_WAYS-1:0][63:0] r_rd_time;

    logic        r_out_valid;
    logic [1:0]  r_out_event;
    logic [63:0] r_out_elapsed;
    logic [31:0] r_out_src;
    logic [31:0] r_out_dst;

    logic [64:0]      mod_full;
    logic [31:0]      mod_prod;
    logic [SET_W-1:0] port_set;
    logic [SET_W-1:0] rd_addr;
    logic             rd_en;
    logic [63:0]      pair;
    logic             hit_found;
    logic [WAY_W-1:0] hit_way;
    logic             free_found;
    logic [WAY_W-1:0] free_way;
    logic [TABLE_WAYS-1:0]       wr_valid_row;
    logic [TABLE_WAYS-1:0][63:0] wr_pair_row;
    logic [TABLE_WAYS-1:0][63:0] wr_time_row;
    logic             wr_valid_en;
    logic             wr_entry_en;
    logic [SET_W-1:0] wr_addr;
    logic [1:0]       res_event;
    logic [63:0]      res_elapsed;

    assign port_set = SET_W'((i_source_address ^ i_destination_address) & SET_MASK);
    assign rd_en    = i_cmd.rd_port | i_cmd.rd_reg;
    assign rd_addr  = i_cmd.rd_port ? port_set : r_mod_rem;

    // The quotient comes from a reciprocal multiply, the remainder in the next cycle.
    assign mod_full = {33'd0, r_mod_x} * {32'd0, MOD_RECIP};
    assign mod_prod = r_mod_q * SETS_32;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_src  <= i_source_address;
            r_dst  <= i_destination_address;
            r_time <= i_timestamp_ns;
            r_qual <= (i_frame_length >= MIN_FRAME_BYTES) && (i_ether_type == ETHERTYPE_IPV4) &&
                      (i_ip_protocol == PROTO_TCP) && i_syn_flag && !i_ack_flag;
        end
        if (i_cmd.mod_start) begin
            r_mod_x <= i_source_address ^ i_destination_address;
        end else if (i_cmd.mod_step) begin
            r_mod_q   <= 32'(mod_full >> MOD_SHIFT);
            r_mod_rem <= SET_W'(r_mod_x - mod_prod);
        end
        if (rd_en) begin
            r_set      <= rd_addr;
            r_rd_valid <= mem_valid[rd_addr];
            r_rd_pair  <= mem_pair[rd_addr];
            r_rd_time  <= mem_time[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt <= '0;
            r_mod_cnt <= 1'b0;
        end else begin
            if (i_cmd.clear_wr) begin
                r_clr_cnt <= r_clr_cnt + SET_W'(1);
            end
            if (i_cmd.mod_start) begin
                r_mod_cnt <= 1'b0;
            end else if (i_cmd.mod_step) begin
                r_mod_cnt <= 1'b1;
            end
        end
    end

    assign pair = {r_src, r_dst};

    always_comb begin
        hit_found  = 1'b0;
        hit_way    = '0;
        free_found = 1'b0;
        free_way   = '0;
        for (int w = TABLE_WAYS - 1; w >= 0; w--) begin
            if (r_rd_valid[w] && (r_rd_pair[w] == pair)) begin
                hit_found = 1'b1;
                hit_way   = WAY_W'(w);
            end
            if (!r_rd_valid[w]) begin
                free_found = 1'b1;
                free_way   = WAY_W'(w);
            end
        end
    end

    always_comb begin
        wr_valid_row = r_rd_valid;
        wr_pair_row  = r_rd_pair;
        wr_time_row  = r_rd_time;
        wr_valid_en  = 1'b0;
        wr_entry_en  = 1'b0;
        res_elapsed  = '0;
        if (!r_qual) begin
            res_event = EV_IGNORED;
        end else if (hit_found) begin
            res_event             = EV_MATCHED;
            res_elapsed           = r_time - r_rd_time[hit_way];
            wr_valid_row[hit_way] = 1'b0;
            wr_valid_en           = i_cmd.resolve;
        end else if (free_found) begin
            res_event              = EV_STORED;
            wr_valid_row[free_way] = 1'b1;
            wr_pair_row[free_way]  = pair;
            wr_time_row[free_way]  = r_time;
            wr_valid_en            = i_cmd.resolve;
            wr_entry_en            = i_cmd.resolve;
        end else begin
            res_event = EV_FULL;
        end
        if (i_cmd.clear_wr) begin
            wr_valid_row = '0;
            wr_valid_en  = 1'b1;
        end
    end

    assign wr_addr = i_cmd.clear_wr ? r_clr_cnt : r_set;

    always_ff @(posedge i_clk) begin
        if (wr_valid_en) begin
            mem_valid[wr_addr] <= wr_valid_row;
        end
        if (wr_entry_en) begin
            mem_pair[wr_addr] <= wr_pair_row;
            mem_time[wr_addr] <= wr_time_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.resolve) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.resolve) begin
            r_out_event   <= res_event;
            r_out_elapsed <= res_elapsed;
            r_out_src     <= r_qual ? r_src : 32'd0;
            r_out_dst     <= r_qual ? r_dst : 32'd0;
        end
    end

    assign o_status.clear_last = (r_clr_cnt == SET_LAST);
    assign o_status.mod_last   = r_mod_cnt;
    assign o_status.out_busy   = r_out_valid && i_out_stall;

    assign o_out_valid        = r_out_valid;
    assign o_event_res        = r_out_event;
    assign o_elapsed_ns       = r_out_elapsed;
    assign o_flow_source      = r_out_src;
    assign o_flow_destination = r_out_dst;

endmodule

[dv/syn_pair_interval_tracker_core_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for syn_pair_interval_tracker_core: a queue-fed driver, a
// randomly stalling receiver and a monitor that checks every result beat against a flow table
// kept here. Depends on syn_pit_pkg and the core RTL.
module syn_pair_interval_tracker_core_tb;
    import syn_pit_pkg::*;

    localparam int SETS         = 2048;
    localparam int WAYS         = 4;
    localparam int HOT_SETS     = 3;
    localparam int HOT_PER_SET  = 6;
    localparam int HOT_PAIRS    = HOT_SETS * HOT_PER_SET;
    localparam int PHASES       = 4;
    localparam int PHASE_BEATS  = 482;
    localparam int LONG_HOLD    = 400;
    localparam int HOLD_AFTER   = 300;
    localparam int IDLE_LIMIT   = 20000;
    localparam int DRAIN_CYCLES = 48;

    typedef struct packed {
        logic [15:0] frame_length;
        logic [15:0] ether_type;
        logic [7:0]  ip_protocol;
        logic [31:0] source_address;
        logic [31:0] destination_address;
        logic        syn_flag;
        logic        ack_flag;
        logic [63:0] timestamp_ns;
    } t_pkt_hdr;

    typedef struct packed {
        logic [1:0]  event_res;
        logic [63:0] elapsed_ns;
        logic [31:0] flow_source;
        logic [31:0] flow_destination;
    } t_flow_report;

    logic        i_clk;
    logic        i_rst_n   = 1'b0;
    logic        in_valid  = 1'b0;
    logic        out_stall = 1'b0;
    t_pkt_hdr    cur_hdr   = '0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [1:0]  o_event_res;
    logic [63:0] o_elapsed_ns;
    logic [31:0] o_flow_source;
    logic [31:0] o_flow_destination;

    t_pkt_hdr     pending_hdrs[$];
    t_flow_report expected_reports[$];

    bit          tbl_valid[SETS * WAYS];
    logic [63:0] tbl_pair[SETS * WAYS];
    logic [63:0] tbl_start[SETS * WAYS];

    logic [31:0] hot_src[HOT_PAIRS];
    logic [31:0] hot_dst[HOT_PAIRS];
    logic [63:0] arrival_ns = 64'd1000;

    int          error_count    = 0;
    int          results_seen   = 0;
    int          idle_cycles    = 0;
    logic        in_taken       = 1'b0;
    int unsigned tx_gap         = 0;
    int unsigned tx_calm        = 0;
    int unsigned rx_hold        = 0;
    int unsigned rx_calm        = 0;
    bit          long_hold_done = 1'b0;

    syn_pair_interval_tracker_core #(
        .TABLE_SETS(SETS),
        .TABLE_WAYS(WAYS)
    ) dut (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_in_valid            (in_valid),
        .o_in_stall            (o_in_stall),
        .i_frame_length        (cur_hdr.frame_length),
        .i_ether_type          (cur_hdr.ether_type),
        .i_ip_protocol         (cur_hdr.ip_protocol),
        .i_source_address      (cur_hdr.source_address),
        .i_destination_address (cur_hdr.destination_address),
        .i_syn_flag            (cur_hdr.syn_flag),
        .i_ack_flag            (cur_hdr.ack_flag),
        .i_timestamp_ns        (cur_hdr.timestamp_ns),
        .o_out_valid           (o_out_valid),
        .i_out_stall           (out_stall),
        .o_event_res           (o_event_res),
        .o_elapsed_ns          (o_elapsed_ns),
        .o_flow_source         (o_flow_source),
        .o_flow_destination    (o_flow_destination)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic t_flow_report predict_flow(t_pkt_hdr h);
        t_flow_report r;
        logic [63:0]  key;
        int           base;
        int           free_way;
        r        = '0;
        free_way = -1;
        if (h.frame_length < MIN_FRAME_BYTES || h.ether_type != ETHERTYPE_IPV4 ||
            h.ip_protocol != PROTO_TCP || h.syn_flag != 1'b1 || h.ack_flag != 1'b0) begin
            r.event_res = EV_IGNORED;
            return r;
        end
        key                = {h.source_address, h.destination_address};
        base               = int'((h.source_address ^ h.destination_address) % SETS) * WAYS;
        r.flow_source      = h.source_address;
        r.flow_destination = h.destination_address;
        for (int w = 0; w < WAYS; w++) begin
            if (tbl_valid[base + w]) begin
                if (tbl_pair[base + w] == key) begin
                    tbl_valid[base + w] = 1'b0;
                    r.event_res         = EV_MATCHED;
                    r.elapsed_ns        = h.timestamp_ns - tbl_start[base + w];
                    return r;
                end
            end else if (free_way < 0) begin
                free_way = w;
            end
        end
        if (free_way < 0) begin
            r.event_res = EV_FULL;
            return r;
        end
        tbl_valid[base + free_way] = 1'b1;
        tbl_pair[base + free_way]  = key;
        tbl_start[base + free_way] = h.timestamp_ns;
        r.event_res                = EV_STORED;
        return r;
    endfunction

    function automatic t_pkt_hdr make_hdr(logic [15:0] len, logic [15:0] eth, logic [7:0] proto,
                                          logic [31:0] src, logic [31:0] dst, logic syn,
                                          logic ack, logic [63:0] ts);
        return '{len, eth, proto, src, dst, syn, ack, ts};
    endfunction

    function automatic int unsigned pick_idle();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 60) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(3, 1);
        end
        return $urandom_range(40, 8);
    endfunction

    function automatic t_pkt_hdr rand_hdr();
        t_pkt_hdr    h;
        int unsigned pick;
        int unsigned idx;
        pick = $urandom_range(99);
        idx  = $urandom_range(HOT_PAIRS - 1);
        if ($urandom_range(9) == 0) begin
            arrival_ns = {$urandom(), $urandom()};
        end else begin
            arrival_ns = arrival_ns + $urandom_range(5000);
        end
        h = make_hdr(16'($urandom_range(65535, MIN_FRAME_BYTES)), ETHERTYPE_IPV4, PROTO_TCP,
                     hot_src[idx], hot_dst[idx], 1'b1, 1'b0, arrival_ns);
        if (pick >= 70 && pick < 80) begin
            h.source_address      = $urandom();
            h.destination_address = $urandom();
        end else if (pick >= 80 && pick < 90) begin
            case ($urandom_range(4))
                0: h.frame_length = 16'($urandom_range(MIN_FRAME_BYTES - 1));
                1: h.ether_type   = ETHERTYPE_IPV4 ^ 16'($urandom_range(65535, 1));
                2: h.ip_protocol  = PROTO_TCP ^ 8'($urandom_range(255, 1));
                3: h.syn_flag     = 1'b0;
                default: h.ack_flag = 1'b1;
            endcase
        end else if (pick >= 90) begin
            h.frame_length        = 16'($urandom());
            h.ether_type          = 16'($urandom());
            h.ip_protocol         = 8'($urandom());
            h.source_address      = $urandom();
            h.destination_address = $urandom();
            h.syn_flag            = 1'($urandom());
            h.ack_flag            = 1'($urandom());
        end
        return h;
    endfunction

    task automatic check_field(input string what, input logic [63:0] want, input logic [63:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $realtime, what, want, got);
            error_count++;
        end
    endtask

    task automatic wait_drained();
        while (pending_hdrs.size() != 0 || in_valid || expected_reports.size() != 0) begin
            @(posedge i_clk);
            #1;
        end
    endtask

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_taken) begin
            if (tx_gap != 0) begin
                in_valid <= 1'b0;
                tx_gap   <= tx_gap - 1;
            end else if (pending_hdrs.size() != 0) begin
                cur_hdr  <= pending_hdrs.pop_front();
                in_valid <= 1'b1;
                if (tx_calm != 0) begin
                    tx_gap  <= 0;
                    tx_calm <= tx_calm - 1;
                end else if ($urandom_range(99) < 2) begin
                    tx_gap  <= 0;
                    tx_calm <= 80;
                end else begin
                    tx_gap <= pick_idle();
                end
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin : receiver
        int unsigned idle;
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else if (rx_hold != 0) begin
            out_stall <= 1'b1;
            rx_hold   <= rx_hold - 1;
        end else if (!long_hold_done && results_seen >= HOLD_AFTER) begin
            long_hold_done <= 1'b1;
            out_stall      <= 1'b1;
            rx_hold        <= LONG_HOLD;
        end else if (rx_calm != 0) begin
            out_stall <= 1'b0;
            rx_calm   <= rx_calm - 1;
        end else if ($urandom_range(199) == 0) begin
            out_stall <= 1'b0;
            rx_calm   <= 150;
        end else begin
            idle = pick_idle();
            if (idle == 0) begin
                out_stall <= 1'b0;
            end else begin
                out_stall <= 1'b1;
                rx_hold   <= idle - 1;
            end
        end
    end

    always @(posedge i_clk) begin : monitor
        t_flow_report got;
        t_flow_report want;
        if (i_rst_n) begin
            in_taken <= in_valid && !o_in_stall;
            if (in_valid && !o_in_stall) begin
                expected_reports.push_back(predict_flow(cur_hdr));
            end
            if (o_out_valid && !out_stall) begin
                got          = {o_event_res, o_elapsed_ns, o_flow_source, o_flow_destination};
                results_seen <= results_seen + 1;
                if (expected_reports.size() == 0) begin
                    $display("%0t: result beat with nothing expected, actual %h", $realtime, got);
                    error_count++;
                end else begin
                    want = expected_reports.pop_front();
                    check_field("event_res", 64'(want.event_res), 64'(got.event_res));
                    check_field("elapsed_ns", want.elapsed_ns, got.elapsed_ns);
                    check_field("flow_source", 64'(want.flow_source), 64'(got.flow_source));
                    check_field("flow_destination", 64'(want.flow_destination),
                                64'(got.flow_destination));
                end
            end
            if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no beat moved for %0d cycles", $realtime, IDLE_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin : stimulus
        logic [31:0] hot_set;
        logic [31:0] src;
        int          idx;
        for (int s = 0; s < HOT_SETS; s++) begin
            hot_set = $urandom_range(SETS - 1);
            for (int j = 0; j < HOT_PER_SET; j++) begin
                idx          = s * HOT_PER_SET + j;
                src          = $urandom();
                hot_src[idx] = src;
                hot_dst[idx] = src ^ hot_set ^ ($urandom() & ~32'(SETS - 1));
            end
        end

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        pending_hdrs.push_back(make_hdr(16'd0, ETHERTYPE_IPV4, PROTO_TCP, 32'h0a000001,
                                        32'h0a000002, 1'b1, 1'b0, 64'd10));
        pending_hdrs.push_back(make_hdr(MIN_FRAME_BYTES - 1, ETHERTYPE_IPV4, PROTO_TCP,
                                        32'h0a000001, 32'h0a000002, 1'b1, 1'b0, 64'd11));
        pending_hdrs.push_back(make_hdr(MIN_FRAME_BYTES, 16'h86dd, PROTO_TCP, 32'h0a000001,
                                        32'h0a000002, 1'b1, 1'b0, 64'd12));
        pending_hdrs.push_back(make_hdr(MIN_FRAME_BYTES, ETHERTYPE_IPV4, 8'd17, 32'h0a000001,
                                        32'h0a000002, 1'b1, 1'b0, 64'd13));
        pending_hdrs.push_back(make_hdr(MIN_FRAME_BYTES, ETHERTYPE_IPV4, PROTO_TCP, 32'h0a000001,
                                        32'h0a000002, 1'b0, 1'b0, 64'd14));
        pending_hdrs.push_back(make_hdr(MIN_FRAME_BYTES, ETHERTYPE_IPV4, PROTO_TCP, 32'h0a000001,
                                        32'h0a000002, 1'b1, 1'b1, 64'd15));
        pending_hdrs.push_back(make_hdr(MIN_FRAME_BYTES, ETHERTYPE_IPV4, PROTO_TCP, 32'h0, 32'h0,
                                        1'b1, 1'b0, 64'd100));
        pending_hdrs.push_back(make_hdr(MIN_FRAME_BYTES, ETHERTYPE_IPV4, PROTO_TCP, 32'h0, 32'h0,
                                        1'b1, 1'b0, 64'd50));
        pending_hdrs.push_back(make_hdr(16'hffff, ETHERTYPE_IPV4, PROTO_TCP, '1, '1, 1'b1, 1'b0,
                                        '1));
        pending_hdrs.push_back(make_hdr(16'hffff, ETHERTYPE_IPV4, PROTO_TCP, '1, '1, 1'b1, 1'b0,
                                        64'd0));
        for (int k = 1; k <= WAYS + 1; k++) begin
            pending_hdrs.push_back(make_hdr(16'd60, ETHERTYPE_IPV4, PROTO_TCP, 32'(k) << 16,
                                            (32'(k) << 16) ^ 32'(SETS - 1), 1'b1, 1'b0,
                                            64'(k * 1000)));
        end
        pending_hdrs.push_back(make_hdr(16'd60, ETHERTYPE_IPV4, PROTO_TCP, 32'h2 << 16,
                                        (32'h2 << 16) ^ 32'(SETS - 1), 1'b1, 1'b0, 64'd7777));
        pending_hdrs.push_back(make_hdr(16'd60, ETHERTYPE_IPV4, PROTO_TCP, 32'h5 << 16,
                                        (32'h5 << 16) ^ 32'(SETS - 1), 1'b1, 1'b0, 64'd8000));
        pending_hdrs.push_back(make_hdr(16'd60, ETHERTYPE_IPV4, PROTO_TCP, 32'h5 << 16,
                                        (32'h5 << 16) ^ 32'(SETS - 1), 1'b1, 1'b0, 64'd9999));
        pending_hdrs.push_back(make_hdr(16'hffff, ETHERTYPE_IPV4, PROTO_TCP, '1, 32'h0, 1'b1,
                                        1'b0, '1));
        pending_hdrs.push_back(make_hdr(16'hffff, ETHERTYPE_IPV4, PROTO_TCP, '1, 32'h0, 1'b1,
                                        1'b0, 64'h8000_0000_0000_0000));
        wait_drained();

        for (int p = 0; p < PHASES; p++) begin
            for (int i = 0; i < PHASE_BEATS; i++) begin
                pending_hdrs.push_back(rand_hdr());
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_reports.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $realtime,
                     expected_reports.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
